/* hdl/avsm_pkg.sv */
// shared widths and default sizes for the av sync index pair matcher
// no dependencies
package avsm_pkg;

  localparam int unsigned SYNC_INDEX_W = 8;
  localparam int unsigned TIME_W = 63;
  localparam int unsigned DEF_TABLE_DEPTH = 128;
  localparam int unsigned DEF_INDEX_BITS = 8;

endpackage

/* hdl/av_sync_index_pair_matcher_core.sv */
// Pairs video and audio sync markers that carry the same index. Pending
// markers sit oldest first in a circular table held in one ram; each accepted
// marker walks the whole table, reading one entry per cycle and writing kept
// entries back compacted. A completed pair waits at the end of its walk only
// if the previous result has not yet been taken.
// depends on avsm_pkg and avsm_ram
module av_sync_index_pair_matcher_core #(
  parameter int unsigned TABLE_DEPTH = avsm_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned INDEX_BITS = avsm_pkg::DEF_INDEX_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [avsm_pkg::SYNC_INDEX_W-1:0] in_sync_index,
  input  logic [avsm_pkg::TIME_W-1:0]       in_event_time,
  input  logic                              in_source_is_video,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [avsm_pkg::SYNC_INDEX_W-1:0] out_match_index,
  output logic [avsm_pkg::TIME_W-1:0]       out_match_video_time,
  output logic [avsm_pkg::TIME_W-1:0]       out_match_audio_time
);
  import avsm_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = INDEX_BITS + TIME_W + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {IDLE, WALK, FIN} state_t;

  state_t                state_r;
  logic [INDEX_BITS-1:0] idx_r;
  logic [TIME_W-1:0]     time_r;
  logic                  vid_r;
  logic [AW-1:0]         base_r, rd_ptr_r, wr_ptr_r;
  logic [CW-1:0]         count_r, rd_cnt_r, wr_cnt_r;
  logic                  ev_v_r, copy_r, pair_r;
  logic [TIME_W-1:0]     hold_vt_r, hold_at_r;
  logic                  out_valid_r;
  logic [SYNC_INDEX_W-1:0] out_idx_r;
  logic [TIME_W-1:0]     out_vt_r, out_at_r;

  logic                  rd_en;
  logic [EW-1:0]         rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;

  logic [INDEX_BITS-1:0] e_idx, diff;
  logic [TIME_W-1:0]     e_time;
  logic                  e_vid, e_nz, same, opp, ahead;
  logic                  keep, hit_pair, hit_equal;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  avsm_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_ptr_r),
    .rd_data(rd_data)
  );

  // entry layout: index, time, video flag; time zero means no marker kind
  assign e_idx  = rd_data[EW-1 -: INDEX_BITS];
  assign e_time = rd_data[TIME_W:1];
  assign e_vid  = rd_data[0];
  assign e_nz   = (e_time != '0);
  assign same   = e_nz && (e_vid == vid_r);
  assign opp    = e_nz && (e_vid != vid_r);
  assign diff   = idx_r - e_idx;
  assign ahead  = diff[INDEX_BITS-1];

  always_comb begin
    keep = 1'b1;
    hit_pair = 1'b0;
    hit_equal = 1'b0;
    if (!copy_r) begin
      if (same && ahead) begin
        keep = 1'b0;
      end else if (e_idx == idx_r) begin
        keep = 1'b0;
        hit_equal = 1'b1;
        hit_pair = opp;
      end
    end
  end

  assign rd_en = (state_r == WALK) && (rd_cnt_r != count_r);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = wr_ptr_r;
    wr_data = {idx_r, time_r, vid_r};
    if (state_r == WALK && ev_v_r && keep) begin
      wr_en = 1'b1;
      wr_data = rd_data;
    end else if (state_r == FIN && !pair_r) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      base_r <= '0;
      count_r <= '0;
      ev_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a pair loading this cycle keeps the output register full
      if (out_valid_r && !out_stall && !(state_r == FIN && pair_r)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (in_valid) begin
            idx_r <= INDEX_BITS'(in_sync_index);
            time_r <= in_event_time;
            vid_r <= in_source_is_video;
            rd_ptr_r <= base_r;
            wr_ptr_r <= base_r;
            rd_cnt_r <= '0;
            wr_cnt_r <= '0;
            ev_v_r <= 1'b0;
            copy_r <= 1'b0;
            pair_r <= 1'b0;
            state_r <= WALK;
          end
        end
        WALK: begin
          ev_v_r <= rd_en;
          if (rd_en) begin
            rd_ptr_r <= ptr_inc(rd_ptr_r);
            rd_cnt_r <= rd_cnt_r + 1'b1;
          end
          if (ev_v_r) begin
            if (keep) begin
              wr_ptr_r <= ptr_inc(wr_ptr_r);
              wr_cnt_r <= wr_cnt_r + 1'b1;
            end
            if (hit_equal) begin
              copy_r <= 1'b1;
            end
            if (hit_pair) begin
              pair_r <= 1'b1;
              hold_vt_r <= vid_r ? time_r : e_time;
              hold_at_r <= vid_r ? e_time : time_r;
            end
          end
          if (!rd_en && !ev_v_r) begin
            state_r <= FIN;
          end
        end
        FIN: begin
          if (pair_r) begin
            if (!out_valid_r || !out_stall) begin
              out_valid_r <= 1'b1;
              out_idx_r <= SYNC_INDEX_W'(idx_r);
              out_vt_r <= hold_vt_r;
              out_at_r <= hold_at_r;
              count_r <= wr_cnt_r;
              state_r <= IDLE;
            end
          end else begin
            // full table: the new entry overwrites the oldest slot
            if (wr_cnt_r == FULL_CNT) begin
              base_r <= ptr_inc(base_r);
              count_r <= wr_cnt_r;
            end else begin
              count_r <= wr_cnt_r + 1'b1;
            end
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != IDLE);
  assign out_valid = out_valid_r;
  assign out_match_index = out_idx_r;
  assign out_match_video_time = out_vt_r;
  assign out_match_audio_time = out_at_r;

endmodule

/* hdl/avsm_ram.sv */
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module avsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/avsm_checker.sv */
// port level checks for av_sync_index_pair_matcher_core, bound to the top level
// depends on avsm_pkg
module avsm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [avsm_pkg::SYNC_INDEX_W-1:0] out_match_index
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_index))
    else $error("stalled result changed");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an accepted marker always walks the table first
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without a walk");

  // a new result only appears at the end of a walk
  a_rose: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a walk");

endmodule

bind av_sync_index_pair_matcher_core avsm_checker u_avsm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_match_index(out_match_index)
);

/* tb/tb_top.sv */
// self-checking testbench for av_sync_index_pair_matcher_core: a pending-marker table predictor
// in the bench checks every completed pair; depends on avsm_pkg and the core rtl
`timescale 1ns / 1ps

module tb_top;
  import avsm_pkg::*;

  localparam int unsigned DEPTH = DEF_TABLE_DEPTH;
  localparam int unsigned IBITS = DEF_INDEX_BITS;
  localparam logic [IBITS-1:0] IHALF = {1'b0, {(IBITS-1){1'b1}}};

  typedef struct packed {
    logic [SYNC_INDEX_W-1:0] idx;
    logic [TIME_W-1:0]       vtime;
    logic [TIME_W-1:0]       atime;
  } marker_pair_t;

  typedef struct packed {
    logic [IBITS-1:0]  idx;
    logic [TIME_W-1:0] vtime;
    logic [TIME_W-1:0] atime;
  } pending_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [SYNC_INDEX_W-1:0] in_sync_index = '0;
  logic [TIME_W-1:0]       in_event_time = '0;
  logic                    in_source_is_video = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [SYNC_INDEX_W-1:0] out_match_index;
  logic [TIME_W-1:0]       out_match_video_time;
  logic [TIME_W-1:0]       out_match_audio_time;

  pending_t     pending_tbl[$];
  marker_pair_t pair_q[$];
  int unsigned  err_cnt = 0;
  int unsigned  in_gap_pct = 30;
  int unsigned  stall_pct = 30;
  int unsigned  stall_run = 0;

  av_sync_index_pair_matcher_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sync_index       (in_sync_index),
    .in_event_time       (in_event_time),
    .in_source_is_video  (in_source_is_video),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_match_index     (out_match_index),
    .out_match_video_time(out_match_video_time),
    .out_match_audio_time(out_match_audio_time)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 150);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (r[TIME_W-1:0] == '0) r[0] = 1'b1;
    return r[TIME_W-1:0];
  endfunction

  // walks the pending table oldest first, same as the block does
  task automatic match_marker(logic [SYNC_INDEX_W-1:0] sidx, logic [TIME_W-1:0] t,
                              logic vid);
    logic [IBITS-1:0] idx;
    logic [IBITS-1:0] idx_gap;
    logic             has_v;
    logic             has_a;
    logic             same_kind;
    logic             opp_kind;
    marker_pair_t     pr;
    pending_t         ent;
    int               i;
    idx = sidx[IBITS-1:0];
    i = 0;
    while (i < pending_tbl.size()) begin
      ent = pending_tbl[i];
      has_v = ent.vtime != '0;
      has_a = ent.atime != '0;
      same_kind = (has_v && vid) || (has_a && !vid);
      opp_kind = (has_v && !vid) || (has_a && vid);
      idx_gap = idx - ent.idx;
      if (same_kind && idx_gap > IHALF) begin
        pending_tbl.delete(i);
        continue;
      end
      if (ent.idx != idx) begin
        i++;
        continue;
      end
      if (opp_kind) begin
        pr.idx = SYNC_INDEX_W'(idx);
        pr.vtime = vid ? t : ent.vtime;
        pr.atime = vid ? ent.atime : t;
        pair_q = {pair_q, pr};
        pending_tbl.delete(i);
        return;
      end
      pending_tbl.delete(i);
      break;
    end
    while (pending_tbl.size() >= DEPTH) pending_tbl.delete(0);
    ent.idx = idx;
    ent.vtime = vid ? t : '0;
    ent.atime = vid ? '0 : t;
    pending_tbl = {pending_tbl, ent};
  endtask

  // caller stands at a rising edge; returns at the edge of acceptance
  task automatic send_marker(logic [SYNC_INDEX_W-1:0] sidx, logic [TIME_W-1:0] t,
                             logic vid);
    int unsigned gap;
    gap = pick_gap(in_gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sync_index <= sidx;
    in_event_time <= t;
    in_source_is_video <= vid;
    do @(posedge clk); while (in_stall);
    match_marker(sidx, t, vid);
  endtask

  task automatic report_mismatch(string what, logic [TIME_W-1:0] got,
                                 logic [TIME_W-1:0] exp);
    $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, exp, $realtime);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    marker_pair_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (pair_q.size() == 0) begin
        report_mismatch("unexpected transaction, index", TIME_W'(out_match_index), '0);
      end else begin
        exp = pair_q[0];
        pair_q.delete(0);
        if (out_match_index !== exp.idx)
          report_mismatch("match_index", TIME_W'(out_match_index), TIME_W'(exp.idx));
        if (out_match_video_time !== exp.vtime)
          report_mismatch("match_video_time", out_match_video_time, exp.vtime);
        if (out_match_audio_time !== exp.atime)
          report_mismatch("match_audio_time", out_match_audio_time, exp.atime);
      end
    end
  end

  task automatic test_directed();
    logic [TIME_W-1:0] tmax;
    tmax = '1;
    send_marker(8'd0, tmax, 1'b1);
    send_marker(8'd0, 63'd1, 1'b0);
    send_marker(8'd255, 63'd1, 1'b0);
    send_marker(8'd255, tmax, 1'b1);
    // duplicate same-kind marker replaces the entry
    send_marker(8'd7, 63'd100, 1'b1);
    send_marker(8'd7, 63'd200, 1'b1);
    send_marker(8'd7, 63'h5555_5555_5555_5555, 1'b0);
    // older same-kind entry with a far index is purged
    send_marker(8'd10, 63'd300, 1'b1);
    send_marker(8'd200, 63'd400, 1'b1);
    send_marker(8'd10, 63'd500, 1'b0);
    send_marker(8'd200, 63'h2aaa_aaaa_aaaa_aaaa, 1'b0);
    // index wrap from 255 to 0
    send_marker(8'd254, 63'd11, 1'b0);
    send_marker(8'd1, 63'd12, 1'b0);
    send_marker(8'd254, 63'd13, 1'b1);
    send_marker(8'd1, 63'd14, 1'b1);
    // zero timestamp entries are neither kind
    send_marker(8'd50, '0, 1'b1);
    send_marker(8'd50, 63'd20, 1'b0);
    send_marker(8'd50, 63'd21, 1'b1);
    send_marker(8'd60, '0, 1'b0);
    send_marker(8'd60, '0, 1'b1);
  endtask

  // zero-time entries are never purged, so the table fills and evicts the oldest
  task automatic test_table_fill();
    send_marker(8'd0, 63'd900, 1'b1);
    for (int k = 1; k <= DEPTH + 6; k++) send_marker(SYNC_INDEX_W'(k), '0, 1'b0);
    send_marker(8'd0, 63'd901, 1'b0);
    send_marker(8'd5, 63'd902, 1'b1);
    send_marker(SYNC_INDEX_W'(DEPTH), 63'd903, 1'b1);
  endtask

  task automatic test_random(int unsigned n_items);
    logic [SYNC_INDEX_W-1:0] base;
    logic [SYNC_INDEX_W-1:0] idx;
    logic                    vid;
    int unsigned             sent;
    base = SYNC_INDEX_W'($urandom);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 75) begin
        // well-formed pair, index drifting forward, optional stray in between
        base = SYNC_INDEX_W'(base + $urandom_range(0, 3));
        idx = SYNC_INDEX_W'(base + $urandom_range(0, 2));
        vid = 1'($urandom_range(0, 1));
        send_marker(idx, rand_time(), vid);
        if ($urandom_range(0, 3) == 0) begin
          send_marker(SYNC_INDEX_W'(base + $urandom_range(0, 5)), rand_time(),
                      1'($urandom_range(0, 1)));
          sent++;
        end
        if ($urandom_range(0, 9) != 0) send_marker(idx, rand_time(), !vid);
        sent += 2;
      end else begin
        send_marker(SYNC_INDEX_W'($urandom), ($urandom_range(0, 29) == 0) ? '0 : rand_time(),
                    1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned wait_cyc;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_fill();
    in_gap_pct = 0;
    stall_pct = 0;
    test_random(90);
    in_gap_pct = 60;
    stall_pct = 60;
    test_random(140);
    in_gap_pct = 20;
    stall_pct = 10;
    test_random(150);
    in_gap_pct = 5;
    stall_pct = 80;
    test_random(110);
    in_valid <= 1'b0;
    wait_cyc = 0;
    while (pair_q.size() > 0 && wait_cyc < 20000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (DEPTH + 20) @(posedge clk);
    if (pair_q.size() > 0)
      report_mismatch("missing transactions, count", TIME_W'(pair_q.size()), '0);
    if (err_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/avsm_pkg.sv
hdl/avsm_ram.sv
hdl/av_sync_index_pair_matcher_core.sv
hdl/avsm_checker.sv
tb/tb_top.sv
